// File: src/tss_pkg.sv
package tss_pkg;

  localparam int DIFF_W     = 32;
  localparam int TIME_W     = 64;
  localparam int PERIOD_W   = 30;
  localparam int SEC_W      = 26;
  localparam int SH_W       = 36;
  localparam int ROUND_STEPS = SH_W / 4;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  localparam logic [DIFF_W:0] ROUND_BIAS = 33'd50;
  localparam logic [7:0]      ROUND_DIV  = 8'd100;

  typedef struct packed {
    logic [DIFF_W-1:0] gap_d;
    logic [DIFF_W-1:0] elapsed_d;
  } tss_item_t;

  // four bits of a restoring divide by one hundred: {remainder, quotient bits}
  function automatic logic [10:0] div100_step4(input logic [6:0] rem_in,
                                               input logic [3:0] nib);
    logic [7:0] acc;
    logic [6:0] rem;
    logic [3:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = 3; i >= 0; i--) begin
      acc = {rem, nib[i]};
      if (acc >= ROUND_DIV) begin
        acc  = acc - ROUND_DIV;
        q[i] = 1'b1;
      end
      rem = acc[6:0];
    end
    return {rem, q};
  endfunction

endpackage

// File: src/tss_front.sv
module tss_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tss_pkg::TIME_W-1:0] ref_time,
  input  logic [tss_pkg::TIME_W-1:0] now_time,
  input  logic                       restart,
  input  logic                       q_full,
  output logic                       q_push,
  output tss_pkg::tss_item_t         q_item
);
  import tss_pkg::*;

  logic [TIME_W-1:0] prev_time;
  logic [TIME_W-1:0] base_time;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign base_time = (prev_time == '0 || restart) ? ref_time : prev_time;

  assign q_item.gap_d     = now_time[DIFF_W-1:0] - base_time[DIFF_W-1:0];
  assign q_item.elapsed_d = now_time[DIFF_W-1:0] - ref_time[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
    end else if (q_push) begin
      prev_time <= now_time;
    end
  end

endmodule

// File: src/tss_queue.sv
module tss_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tss_pkg::tss_item_t push_item,
  output logic               full,
  input  logic               pop,
  output tss_pkg::tss_item_t pop_item,
  output logic               empty
);
  import tss_pkg::*;

  tss_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/tss_back.sv
module tss_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tss_pkg::PERIOD_W-1:0] slice_period,
  input  logic                         q_empty,
  input  tss_pkg::tss_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         selected
);
  import tss_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    ROUND,
    DIVIDE,
    EVAL
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [SH_W-1:0]     gap_sh;
  logic [SH_W-1:0]     el_sh;
  logic [6:0]          gap_rem;
  logic [6:0]          el_rem;
  logic [SEC_W-1:0]    gap_sec;
  logic [SEC_W-1:0]    el_bits;
  logic [PERIOD_W-1:0] rem;

  logic [10:0]         gap_step;
  logic [10:0]         el_step;
  logic [SH_W-1:0]     gap_sh_next;
  logic [SH_W-1:0]     el_sh_next;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   rem_w;
  logic [PERIOD_W-1:0] rem_next;
  logic [SEC_W-2:0]    g_half;
  logic [SEC_W-1:0]    g_ceil;
  logic [PERIOD_W-1:0] to_next;
  logic                sel_next;
  logic [DIFF_W:0]     gap_biased;
  logic [DIFF_W:0]     el_biased;

  assign period = (slice_period == '0) ? PERIOD_W'(1) : slice_period;
  assign q_pop  = (state == IDLE) && !q_empty;

  assign gap_biased = {1'b0, q_item.gap_d} + ROUND_BIAS;
  assign el_biased  = {1'b0, q_item.elapsed_d} + ROUND_BIAS;

  assign gap_step    = div100_step4(gap_rem, gap_sh[SH_W-1 -: 4]);
  assign el_step     = div100_step4(el_rem, el_sh[SH_W-1 -: 4]);
  assign gap_sh_next = {gap_sh[SH_W-5:0], gap_step[3:0]};
  assign el_sh_next  = {el_sh[SH_W-5:0], el_step[3:0]};

  always_comb begin
    rem_w = {rem, el_bits[SEC_W-1]};
    if (rem_w >= {1'b0, period}) begin
      rem_w = rem_w - {1'b0, period};
    end
    rem_next = rem_w[PERIOD_W-1:0];
  end

  // lower multiple is elapsed - rem, upper is elapsed - rem + period
  assign g_half   = gap_sec[SEC_W-1:1];
  assign g_ceil   = gap_sec - {1'b0, g_half};
  assign to_next  = period - rem;
  assign sel_next = (rem <= PERIOD_W'(g_half) && (rem != '0 || gap_sec != '0)) ||
                    (to_next < PERIOD_W'(g_ceil));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (!q_empty) begin
            gap_sh  <= SH_W'(gap_biased);
            el_sh   <= SH_W'(el_biased);
            gap_rem <= '0;
            el_rem  <= '0;
            cnt     <= '0;
            state   <= ROUND;
          end
        end
        ROUND: begin
          gap_sh  <= gap_sh_next;
          el_sh   <= el_sh_next;
          gap_rem <= gap_step[10:4];
          el_rem  <= el_step[10:4];
          cnt     <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROUND_STEPS - 1)) begin
            gap_sec <= gap_sh_next[SEC_W-1:0];
            el_bits <= el_sh_next[SEC_W-1:0];
            rem     <= '0;
            cnt     <= '0;
            state   <= DIVIDE;
          end
        end
        DIVIDE: begin
          rem     <= rem_next;
          el_bits <= {el_bits[SEC_W-2:0], 1'b0};
          cnt     <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SEC_W - 1)) begin
            state <= EVAL;
          end
        end
        EVAL: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            selected  <= sel_next;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: src/timestamp_slice_selector.sv
// Per beat, in order: pop, radix-16 rounding of both differences, restoring
//   remainder by slice_period, then eval; a further beat is popped only after eval,
//   which waits while a previous output beat is stalled.
// The front end takes up to two beats ahead through a two-entry queue.
// Reset: synchronous, active high; clears previous time, queue, output valid,
//   and sets slice_period to 1.
module timestamp_slice_selector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tss_pkg::PERIOD_W-1:0]    cfg_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // ref_time[63:0], now_time[127:64], restart[128], zero [135:129]
  input  logic [tss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // selected[0], zero [7:1]
  output logic [tss_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import tss_pkg::*;

  logic [PERIOD_W-1:0] slice_period;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  tss_item_t           push_item;
  tss_item_t           pop_item;
  logic                selected;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_period <= PERIOD_W'(1);
    end else if (cfg_wr_en) begin
      slice_period <= cfg_wr_data;
    end
  end

  tss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .ref_time (s_axis_tdata[63:0]),
    .now_time (s_axis_tdata[127:64]),
    .restart  (s_axis_tdata[128]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  tss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  tss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .slice_period (slice_period),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .selected     (selected)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, selected};

endmodule

// File: src/tss_checker.sv
module tss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tss_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("output padding not zero");

endmodule

bind timestamp_slice_selector tss_checker u_tss_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
